// File: sv/gmr_pkg.sv
// Shared widths, constants and item types for the group mean rebinning core.
// No dependencies; gmr_finish and the core import this package.
`timescale 1ns / 1ps

package gmr_pkg;

  localparam int CONTENT_W = 32;
  localparam int ERROR_W   = 29;
  localparam int COUNT_W   = 6;
  localparam int GSIZE_W   = 6;
  localparam int CSUM_W    = 37;
  localparam int ESQ_W     = 64;
  localparam int ROOT_W    = ESQ_W / 2;
  localparam int DIGIT_W   = 8;
  localparam int N_DIGITS  = (ERROR_W + DIGIT_W - 1) / DIGIT_W;
  localparam int PROD_W    = ERROR_W + DIGIT_W;
  localparam int MIN_GROUP = 8;
  localparam int MAX_GROUP = 32;

  localparam logic [GSIZE_W-1:0] GROUP_SIZE_RST = GSIZE_W'(10);

  typedef struct packed {
    logic signed [CONTENT_W-1:0] bin_content;
    logic [ERROR_W-1:0]          bin_error;
  } in_item_t;

  typedef struct packed {
    logic signed [CONTENT_W-1:0] mean_content;
    logic [ERROR_W-1:0]          mean_error;
    logic [COUNT_W-1:0]          nonzero_count;
  } out_item_t;

  typedef logic [GSIZE_W-1:0] cfg_item_t;

  typedef struct packed {
    logic                     start;
    logic signed [CSUM_W-1:0] content_sum;
    logic [ESQ_W-1:0]         error_square_sum;
    logic [COUNT_W-1:0]       used_count;
  } fin_req_t;

endpackage

// File: sv/gmr_chan_if.sv
// Valid/ready channel carrying one payload of a given type per transfer.
// No dependencies; payload types come from gmr_pkg at the point of use.
`timescale 1ns / 1ps

interface gmr_chan_if #(parameter type payload_t = logic);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// File: sv/gmr_finish.sv
// End-of-group unit: bit-serial restoring divider and two-bit-per-cycle square root,
// plus the result output register. Depends on gmr_pkg and gmr_chan_if.
`timescale 1ns / 1ps

module gmr_finish
  import gmr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  fin_req_t   req,
  output logic       idle,
  gmr_chan_if.source out_ch
);

  localparam logic [1:0] F_IDLE  = 2'd0;
  localparam logic [1:0] F_STEP1 = 2'd1;
  localparam logic [1:0] F_STEP2 = 2'd2;
  localparam logic [1:0] F_OUT   = 2'd3;

  localparam int STEP_W = $clog2(CSUM_W);
  localparam int SREM_W = ROOT_W + 3;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CSUM_W - 1);
  localparam logic [STEP_W-1:0] ROOT_STEPS = STEP_W'(ROOT_W);

  logic [1:0]           fstate_r, fstate_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic                 ov_r, ov_nxt;
  logic [COUNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 neg_r, neg_nxt;
  logic [CSUM_W-1:0]    qd_r, qd_nxt;
  logic [COUNT_W-1:0]   drem_r, drem_nxt;
  logic [ESQ_W-1:0]     rad_r, rad_nxt;
  logic [SREM_W-1:0]    srem_r, srem_nxt;
  logic [ROOT_W-1:0]    root_r, root_nxt;
  logic [CONTENT_W-1:0] qc_r, qc_nxt;
  out_item_t            out_r, out_nxt;

  logic [COUNT_W:0]     dt;
  logic                 dge;
  logic [COUNT_W:0]     dsub;
  logic [CSUM_W-1:0]    qd_step;
  logic [COUNT_W-1:0]   drem_step;
  logic [SREM_W-1:0]    st;
  logic [SREM_W-1:0]    trial;
  logic                 sge;
  logic [CONTENT_W-1:0] qc_mag;
  logic                 out_free;

  // divider step: one quotient bit
  assign dt        = {drem_r, qd_r[CSUM_W-1]};
  assign dge       = dt >= {1'b0, cnt_r};
  assign dsub      = dt - {1'b0, cnt_r};
  assign drem_step = dge ? dsub[COUNT_W-1:0] : dt[COUNT_W-1:0];
  assign qd_step   = {qd_r[CSUM_W-2:0], dge};

  // square root step: two radicand bits, one root bit
  assign st    = {srem_r[SREM_W-3:0], rad_r[ESQ_W-1 -: 2]};
  assign trial = SREM_W'({root_r, 2'b01});
  assign sge   = st >= trial;

  assign qc_mag   = qd_step[CONTENT_W-1:0];
  assign out_free = !ov_r || out_ch.ready;

  assign idle         = (fstate_r == F_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.data  = out_r;

  always_comb begin
    fstate_nxt = fstate_r;
    step_nxt   = step_r;
    ov_nxt     = ov_r && !out_ch.ready;
    cnt_nxt    = cnt_r;
    neg_nxt    = neg_r;
    qd_nxt     = qd_r;
    drem_nxt   = drem_r;
    rad_nxt    = rad_r;
    srem_nxt   = srem_r;
    root_nxt   = root_r;
    qc_nxt     = qc_r;
    out_nxt    = out_r;
    case (fstate_r)
      F_IDLE: begin
        if (req.start) begin
          cnt_nxt    = req.used_count;
          neg_nxt    = req.content_sum[CSUM_W-1];
          qd_nxt     = req.content_sum[CSUM_W-1] ? (~req.content_sum + 1'b1)
                                                 : req.content_sum;
          drem_nxt   = '0;
          rad_nxt    = req.error_square_sum;
          srem_nxt   = '0;
          root_nxt   = '0;
          step_nxt   = '0;
          fstate_nxt = F_STEP1;
        end
      end
      F_STEP1: begin
        qd_nxt   = qd_step;
        drem_nxt = drem_step;
        if (step_r < ROOT_STEPS) begin
          srem_nxt = sge ? (st - trial) : st;
          root_nxt = {root_r[ROOT_W-2:0], sge};
          rad_nxt  = rad_r << 2;
        end
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          qc_nxt     = neg_r ? (~qc_mag + 1'b1) : qc_mag;
          qd_nxt     = CSUM_W'(root_r);
          drem_nxt   = '0;
          step_nxt   = '0;
          fstate_nxt = F_STEP2;
        end
      end
      F_STEP2: begin
        qd_nxt   = qd_step;
        drem_nxt = drem_step;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          fstate_nxt = F_OUT;
        end
      end
      F_OUT: begin
        if (out_free) begin
          out_nxt.nonzero_count = cnt_r;
          out_nxt.mean_content  = (cnt_r == '0) ? '0 : qc_r;
          out_nxt.mean_error    = (cnt_r == '0) ? '0 : qd_r[ERROR_W-1:0];
          ov_nxt                = 1'b1;
          fstate_nxt            = F_IDLE;
        end
      end
      default: begin
        fstate_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fstate_r <= F_IDLE;
      step_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      fstate_r <= fstate_nxt;
      step_r   <= step_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    neg_r  <= neg_nxt;
    qd_r   <= qd_nxt;
    drem_r <= drem_nxt;
    rad_r  <= rad_nxt;
    srem_r <= srem_nxt;
    root_r <= root_nxt;
    qc_r   <= qc_nxt;
    out_r  <= out_nxt;
  end

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> fstate_r == F_IDLE)
    else $error("group handed over while finisher busy");

  a_empty_group_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.nonzero_count == '0)
      |-> (out_ch.data.mean_content == '0 && out_ch.data.mean_error == '0))
    else $error("empty group gives nonzero mean");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (fstate_r == F_OUT && !ov_r) |=> (out_ch.valid && fstate_r == F_IDLE))
    else $error("finished result not loaded into free output register");

endmodule

// File: sv/group_mean_with_error_rebin_core.sv
// Each bin's error is squared one 8-bit digit per cycle; a group's result then passes
// the hand-over, the finisher's two 37-step serial divisions (the square root running
// beside the first) and its output register. A new bin is taken only once the previous
// one's digits are done; a group that ends while the finisher is busy waits in the hand-over.
// Reset: synchronous, active low; sums, counts and handshakes clear, group size is 10.
`timescale 1ns / 1ps

module group_mean_with_error_rebin_core
  import gmr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  gmr_chan_if.sink   in_ch,
  gmr_chan_if.sink   cfg_ch,
  gmr_chan_if.source out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAC  = 2'd1;
  localparam logic [1:0] ST_HAND = 2'd2;

  localparam int DIG_W = $clog2(N_DIGITS);
  localparam logic [DIG_W-1:0] DIG_LAST = DIG_W'(N_DIGITS - 1);

  logic [1:0]         state_r, state_nxt;
  logic [GSIZE_W-1:0] gsize_r;
  logic [CSUM_W-1:0]  csum_r, csum_nxt;
  logic [ESQ_W-1:0]   esq_r, esq_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [GSIZE_W-1:0] pos_r, pos_nxt;
  logic [DIG_W-1:0]   dig_r, dig_nxt;
  logic [ERROR_W-1:0] err_r, err_nxt;
  logic [ERROR_W-1:0] mplr_r, mplr_nxt;
  logic               end_r, end_nxt;

  logic               in_acc;
  logic               nz;
  logic [ERROR_W-1:0] in_err;
  logic [ERROR_W-1:0] mcand;
  logic [DIGIT_W-1:0] digit;
  logic [DIG_W-1:0]   dig_sel;
  logic [PROD_W-1:0]  prod;
  logic [ESQ_W-1:0]   pp;
  logic [GSIZE_W-1:0] size_eff;
  logic [GSIZE_W-1:0] pos_inc;
  logic               fin_idle;
  fin_req_t           fin_req;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign nz     = (in_ch.data.bin_content != '0);
  assign in_err = nz ? in_ch.data.bin_error : '0;

  assign mcand   = (state_r == ST_IDLE) ? in_err : err_r;
  assign digit   = (state_r == ST_IDLE) ? in_err[DIGIT_W-1:0] : mplr_r[DIGIT_W-1:0];
  assign dig_sel = (state_r == ST_IDLE) ? '0 : dig_r;
  assign prod    = PROD_W'(mcand) * PROD_W'(digit);
  assign pp      = ESQ_W'(prod) << (DIGIT_W * int'(dig_sel));

  always_comb begin
    size_eff = gsize_r;
    if (gsize_r < GSIZE_W'(MIN_GROUP)) begin
      size_eff = GSIZE_W'(MIN_GROUP);
    end else if (gsize_r > GSIZE_W'(MAX_GROUP)) begin
      size_eff = GSIZE_W'(MAX_GROUP);
    end
  end

  assign pos_inc = pos_r + 1'b1;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign fin_req.start            = (state_r == ST_HAND) && fin_idle;
  assign fin_req.content_sum      = csum_r;
  assign fin_req.error_square_sum = esq_r;
  assign fin_req.used_count       = cnt_r;

  always_comb begin
    state_nxt = state_r;
    csum_nxt  = csum_r;
    esq_nxt   = esq_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    dig_nxt   = dig_r;
    err_nxt   = err_r;
    mplr_nxt  = mplr_r;
    end_nxt   = end_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          csum_nxt  = csum_r + {{(CSUM_W-CONTENT_W){in_ch.data.bin_content[CONTENT_W-1]}},
                                in_ch.data.bin_content};
          esq_nxt   = esq_r + pp;
          cnt_nxt   = cnt_r + COUNT_W'(nz);
          pos_nxt   = pos_inc;
          end_nxt   = (pos_inc >= size_eff);
          err_nxt   = in_err;
          mplr_nxt  = in_err >> DIGIT_W;
          dig_nxt   = DIG_W'(1);
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        esq_nxt  = esq_r + pp;
        mplr_nxt = mplr_r >> DIGIT_W;
        dig_nxt  = dig_r + 1'b1;
        if (dig_r == DIG_LAST) begin
          state_nxt = end_r ? ST_HAND : ST_IDLE;
        end
      end
      ST_HAND: begin
        if (fin_idle) begin
          csum_nxt  = '0;
          esq_nxt   = '0;
          cnt_nxt   = '0;
          pos_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      gsize_r <= GROUP_SIZE_RST;
      csum_r  <= '0;
      esq_r   <= '0;
      cnt_r   <= '0;
      pos_r   <= '0;
      dig_r   <= '0;
    end else begin
      state_r <= state_nxt;
      csum_r  <= csum_nxt;
      esq_r   <= esq_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
      dig_r   <= dig_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        gsize_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    err_r  <= err_nxt;
    mplr_r <= mplr_nxt;
    end_r  <= end_nxt;
  end

  gmr_finish u_finish (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (fin_req),
    .idle   (fin_idle),
    .out_ch (out_ch)
  );

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("input taken again during digit accumulation");

  a_count_within_position: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= pos_r)
    else $error("nonzero count exceeds bins seen in group");

  a_position_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= GSIZE_W'(MAX_GROUP))
    else $error("group position beyond largest group");

endmodule
